// ===== hdl/image_header_dimension_sniffer_defines.svh =====
// Assertion macros used by the checker file of the header sniffer.
`ifndef IMAGE_HEADER_DIMENSION_SNIFFER_DEFINES_SVH
`define IMAGE_HEADER_DIMENSION_SNIFFER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IHDS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ihds check failed");

// Next-cycle implication, disabled while reset is high.
`define IHDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ihds check failed");

`endif

// ===== hdl/ihds_pkg.sv =====
// Types, constants and codes for the image header dimension sniffer.
package ihds_pkg;

  localparam int POSITION_BITS = 32;
  localparam int HEADER_BYTES  = 24;
  localparam int CAPTURE_BYTES = 9;
  localparam int HDR_IDX_W     = $clog2(HEADER_BYTES);
  localparam int CAP_IDX_W     = $clog2(CAPTURE_BYTES + 1);
  localparam int SUM_BITS      = POSITION_BITS + 1;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [SUM_BITS-1:0]      sum_t;
  typedef logic [CAP_IDX_W-1:0]     cap_idx_t;

  localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};

  // Byte positions within the header
  localparam int LEN_LO_POS  = 5;
  localparam int LEN_HI_POS  = 4;
  localparam int MARKER_HEAD = 4;
  localparam int MIN_SEG_LEN = 4;

  // Walk phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SEEK    = 3'd1;
  localparam logic [2:0] PH_CAPTURE = 3'd2;
  localparam logic [2:0] PH_FOUND   = 3'd3;
  localparam logic [2:0] PH_FAILED  = 3'd4;

  // Format codes
  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_JFIF = 3'd1;
  localparam logic [2:0] FMT_JPEG = 3'd2;
  localparam logic [2:0] FMT_GIF  = 3'd3;
  localparam logic [2:0] FMT_PNG  = 3'd4;

  // Signature bytes
  localparam logic [7:0] B_FF  = 8'hFF;
  localparam logic [7:0] B_D8  = 8'hD8;
  localparam logic [7:0] B_E0  = 8'hE0;
  localparam logic [7:0] B_C0  = 8'hC0;
  localparam logic [7:0] B_89  = 8'h89;
  localparam logic [7:0] B_0D  = 8'h0D;
  localparam logic [7:0] B_0A  = 8'h0A;
  localparam logic [7:0] B_1A  = 8'h1A;
  localparam logic [7:0] B_00  = 8'h00;
  localparam logic [7:0] CH_J  = 8'h4A;
  localparam logic [7:0] CH_F  = 8'h46;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_P  = 8'h50;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_R  = 8'h52;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } byte_beat_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  format_code;
    logic [31:0] width;
    logic [31:0] height;
  } result_beat_t;

endpackage

// ===== hdl/image_header_dimension_sniffer.sv =====
// Image header dimension sniffer: top level and all parsing logic.
//
// Usage:
//   Byte channel (byte_valid/byte_stall/byte_data): one file byte per beat,
//   first_byte marks the start of a file, last_byte its end. Bytes arriving
//   without a file open (no first_byte since the last result) are dropped.
//   Result channel (result_valid/result_stall/result_data): one beat per file,
//   issued for the beat carrying last_byte: found, format code, width, height.
//   A byte is taken into the input register and parsed from there; its
//   result is registered in the result register that drives result_valid.
//   Throughput: one byte per cycle while byte_stall is low; the byte position
//   compare and the segment target adder sit in the single parse stage.
//   Reset (rst, synchronous, active high) empties both registers and waits
//   for a first byte. While the receiver stalls, the result beat holds and
//   bytes without last_byte keep flowing; a second result waits in the
//   input register and byte_stall rises until the result register frees.
//   Files under 24 bytes report not found.
module image_header_dimension_sniffer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  ihds_pkg::byte_beat_t   byte_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output ihds_pkg::result_beat_t result_data
);

  // Input register
  logic                 s1_valid;
  ihds_pkg::byte_beat_t s1;

  // Parse state
  ihds_pkg::pos_t     byte_position;
  ihds_pkg::pos_t     segment_target;
  ihds_pkg::cap_idx_t capture_index;
  logic               result_done;
  logic [2:0]         phase;
  logic [7:0]         header_store   [ihds_pkg::HEADER_BYTES];
  logic [7:0]         marker_capture [ihds_pkg::CAPTURE_BYTES];

  // Next values
  ihds_pkg::pos_t     byte_position_next;
  ihds_pkg::pos_t     segment_target_next;
  ihds_pkg::cap_idx_t capture_index_next;
  logic [2:0]         phase_next;
  logic [7:0]         header_store_next   [ihds_pkg::HEADER_BYTES];
  logic [7:0]         marker_capture_next [ihds_pkg::CAPTURE_BYTES];

  logic                   active;
  logic                   gives_result;
  logic                   s1_fire;
  logic                   out_free;
  ihds_pkg::pos_t         pos_eff;
  ihds_pkg::pos_t         tgt_eff;
  logic [15:0]            seg_len;
  ihds_pkg::sum_t         tgt_sum;
  logic                   is_jfif;
  logic                   is_jpeg;
  logic                   is_gif;
  logic                   is_png;
  logic                   long_enough;
  ihds_pkg::result_beat_t res_c;

  assign active       = s1.first_byte || !result_done;
  assign gives_result = s1_valid && active && s1.last_byte;
  assign out_free     = !result_valid || !result_stall;
  assign s1_fire      = s1_valid && (!gives_result || out_free);
  assign byte_stall   = s1_valid && !s1_fire;

  // Walk and header capture for the byte in the input register
  always_comb begin
    pos_eff             = s1.first_byte ? '0 : byte_position;
    tgt_eff             = s1.first_byte ? '0 : segment_target;
    capture_index_next  = s1.first_byte ? '0 : capture_index;
    phase_next          = s1.first_byte ? ihds_pkg::PH_IDLE : phase;
    segment_target_next = tgt_eff;
    header_store_next   = header_store;
    marker_capture_next = marker_capture;
    seg_len             = '0;
    tgt_sum             = '0;

    if (pos_eff < ihds_pkg::pos_t'(ihds_pkg::HEADER_BYTES)) begin
      header_store_next[pos_eff[ihds_pkg::HDR_IDX_W-1:0]] = s1.data_byte;
    end

    if (pos_eff == ihds_pkg::pos_t'(ihds_pkg::LEN_LO_POS)) begin
      seg_len = {header_store[ihds_pkg::LEN_HI_POS], s1.data_byte};
      tgt_sum = ihds_pkg::sum_t'(ihds_pkg::MARKER_HEAD) + ihds_pkg::sum_t'(seg_len);
      if (seg_len < 16'(ihds_pkg::MIN_SEG_LEN)) begin
        phase_next = ihds_pkg::PH_FAILED;
      end else begin
        segment_target_next = ihds_pkg::pos_t'(tgt_sum);
        phase_next = (tgt_sum >= ihds_pkg::sum_t'(ihds_pkg::POS_MAX)) ?
                     ihds_pkg::PH_FAILED : ihds_pkg::PH_SEEK;
      end
    end else begin
      if (phase_next == ihds_pkg::PH_SEEK && pos_eff == tgt_eff) begin
        phase_next         = ihds_pkg::PH_CAPTURE;
        capture_index_next = '0;
      end
      if (phase_next == ihds_pkg::PH_CAPTURE) begin
        if (capture_index_next < ihds_pkg::cap_idx_t'(ihds_pkg::CAPTURE_BYTES)) begin
          marker_capture_next[capture_index_next] = s1.data_byte;
        end
        capture_index_next = capture_index_next + 1'b1;
        if (capture_index_next == ihds_pkg::cap_idx_t'(ihds_pkg::MARKER_HEAD)) begin
          if (marker_capture_next[0] != ihds_pkg::B_FF) begin
            phase_next = ihds_pkg::PH_FAILED;
          end else if (marker_capture_next[1] != ihds_pkg::B_C0) begin
            seg_len = {marker_capture_next[2], marker_capture_next[3]};
            tgt_sum = ihds_pkg::sum_t'(tgt_eff) + ihds_pkg::sum_t'(seg_len);
            if (seg_len < 16'(ihds_pkg::MIN_SEG_LEN)) begin
              phase_next = ihds_pkg::PH_FAILED;
            end else begin
              segment_target_next = ihds_pkg::pos_t'(tgt_sum);
              phase_next = (tgt_sum >= ihds_pkg::sum_t'(ihds_pkg::POS_MAX)) ?
                           ihds_pkg::PH_FAILED : ihds_pkg::PH_SEEK;
            end
          end
        end else if (capture_index_next >=
                     ihds_pkg::cap_idx_t'(ihds_pkg::CAPTURE_BYTES)) begin
          phase_next = ihds_pkg::PH_FOUND;
        end
      end
    end

    // Hold the position on the last byte, else advance and saturate
    if (s1.last_byte || pos_eff == ihds_pkg::POS_MAX) begin
      byte_position_next = pos_eff;
    end else begin
      byte_position_next = pos_eff + 1'b1;
    end
  end

  // Format decision, on the header as it stands after this byte
  always_comb begin
    long_enough = pos_eff >= ihds_pkg::pos_t'(ihds_pkg::HEADER_BYTES - 1);
    is_jpeg = header_store_next[0] == ihds_pkg::B_FF &&
              header_store_next[1] == ihds_pkg::B_D8 &&
              header_store_next[2] == ihds_pkg::B_FF;
    is_jfif = is_jpeg && header_store_next[3] == ihds_pkg::B_E0 &&
              header_store_next[6] == ihds_pkg::CH_J &&
              header_store_next[7] == ihds_pkg::CH_F &&
              header_store_next[8] == ihds_pkg::CH_I &&
              header_store_next[9] == ihds_pkg::CH_F &&
              header_store_next[10] == ihds_pkg::B_00;
    is_gif  = header_store_next[0] == ihds_pkg::CH_G &&
              header_store_next[1] == ihds_pkg::CH_I &&
              header_store_next[2] == ihds_pkg::CH_F;
    is_png  = header_store_next[0] == ihds_pkg::B_89 &&
              header_store_next[1] == ihds_pkg::CH_P &&
              header_store_next[2] == ihds_pkg::CH_N &&
              header_store_next[3] == ihds_pkg::CH_G &&
              header_store_next[4] == ihds_pkg::B_0D &&
              header_store_next[5] == ihds_pkg::B_0A &&
              header_store_next[6] == ihds_pkg::B_1A &&
              header_store_next[7] == ihds_pkg::B_0A &&
              header_store_next[12] == ihds_pkg::CH_I &&
              header_store_next[13] == ihds_pkg::CH_H &&
              header_store_next[14] == ihds_pkg::CH_D &&
              header_store_next[15] == ihds_pkg::CH_R;

    res_c = '0;
    if (long_enough) begin
      if (is_jfif) begin
        // A JFIF header without a completed walk reports nothing
        if (phase_next == ihds_pkg::PH_FOUND) begin
          res_c.format_code = ihds_pkg::FMT_JFIF;
          res_c.height = {16'h0000, marker_capture_next[5], marker_capture_next[6]};
          res_c.width  = {16'h0000, marker_capture_next[7], marker_capture_next[8]};
        end
      end else if (is_jpeg) begin
        res_c.format_code = ihds_pkg::FMT_JPEG;
        res_c.height = {16'h0000, header_store_next[7], header_store_next[8]};
        res_c.width  = {16'h0000, header_store_next[9], header_store_next[10]};
      end else if (is_gif) begin
        res_c.format_code = ihds_pkg::FMT_GIF;
        res_c.width  = {16'h0000, header_store_next[7], header_store_next[6]};
        res_c.height = {16'h0000, header_store_next[9], header_store_next[8]};
      end else if (is_png) begin
        res_c.format_code = ihds_pkg::FMT_PNG;
        res_c.width  = {header_store_next[16], header_store_next[17],
                        header_store_next[18], header_store_next[19]};
        res_c.height = {header_store_next[20], header_store_next[21],
                        header_store_next[22], header_store_next[23]};
      end
    end
    res_c.found = res_c.format_code != ihds_pkg::FMT_NONE;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
    if (!byte_stall && byte_valid) begin
      s1 <= byte_data;
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      segment_target <= '0;
      capture_index  <= '0;
      result_done    <= 1'b1;
      phase          <= ihds_pkg::PH_IDLE;
    end else if (s1_fire && active) begin
      byte_position  <= byte_position_next;
      segment_target <= segment_target_next;
      capture_index  <= capture_index_next;
      result_done    <= s1.last_byte;
      phase          <= phase_next;
    end
    if (s1_fire && active) begin
      header_store   <= header_store_next;
      marker_capture <= marker_capture_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && gives_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (s1_fire && gives_result) begin
      result_data <= res_c;
    end
  end

endmodule

// ===== hdl/ihds_checker.sv =====
// Port-level checks for the image header dimension sniffer, bound to the top level.
`include "image_header_dimension_sniffer_defines.svh"

module ihds_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   byte_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input ihds_pkg::result_beat_t result_data
);

  logic res_waits;
  logic failed_beat;
  logic found_beat;
  logic short_beat;
  logic all_zero;
  logic real_code;
  logic narrow_size;

  assign res_waits   = result_valid && result_stall;
  assign failed_beat = result_valid && !result_data.found;
  assign found_beat  = result_valid && result_data.found;
  assign short_beat  = result_valid && result_data.format_code != ihds_pkg::FMT_PNG;
  assign all_zero    = result_data.format_code == ihds_pkg::FMT_NONE &&
                       result_data.width == '0 && result_data.height == '0;
  assign real_code   = result_data.format_code == ihds_pkg::FMT_JFIF ||
                       result_data.format_code == ihds_pkg::FMT_JPEG ||
                       result_data.format_code == ihds_pkg::FMT_GIF ||
                       result_data.format_code == ihds_pkg::FMT_PNG;
  assign narrow_size = result_data.width[31:16] == 16'h0000 &&
                       result_data.height[31:16] == 16'h0000;

  // A failed file reports all zero
  `IHDS_ASSERT_NOW(a_fail_zero, clk, rst, failed_beat, all_zero)

  // Found flag and a real format code go together
  `IHDS_ASSERT_NOW(a_found_code, clk, rst, found_beat, real_code)

  // Only PNG carries sizes above 16 bits
  `IHDS_ASSERT_NOW(a_narrow_size, clk, rst, short_beat, narrow_size)

  // A stalled result beat holds
  `IHDS_ASSERT_NEXT(a_res_hold, clk, rst, res_waits, result_valid && $stable(result_data))

  // The byte side only stalls behind a waiting result beat
  `IHDS_ASSERT_NOW(a_stall_cause, clk, rst, byte_stall, res_waits)

endmodule

bind image_header_dimension_sniffer ihds_checker u_ihds_checker (.*);
